### rtl/core/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  // Largest supported matrix dimension by default.
  localparam int DIM_DEFAULT = 8;

  // Fixed field widths.
  localparam int IDX_W   = 3;
  localparam int VALUE_W = 16;
  localparam int MUL_W   = 2 * VALUE_W;
  localparam int PROD_W  = 35;
  localparam int SIZE_W  = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 2'd3;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic             load_wr;
    logic             rd_en;
    logic             clear_acc;
    logic             load_out;
    logic             last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_done;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/swm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/swm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl #(
  parameter int DIM = swm_pkg::DIM_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [swm_pkg::SIZE_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  input  wire logic                       start_req,
  output logic                            in_stall,
  input  wire swm_pkg::sts_t              sts,
  output swm_pkg::cmd_t                   cmd
);

  localparam int DimLog = $clog2(DIM + 1) - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t                       state;
  logic [swm_pkg::SIZE_W-1:0]   size_log2;
  logic [swm_pkg::IDX_W-1:0]    i;
  logic [swm_pkg::IDX_W-1:0]    j;
  logic [swm_pkg::IDX_W-1:0]    k;
  logic [1:0]                   drain_cnt;
  logic [swm_pkg::SIZE_W-1:0]   eff_log;
  logic [swm_pkg::IDX_W-1:0]    nm1;
  logic                         accept;
  logic                         last_elem;

  // Active size saturates to the largest power of two that fits.
  always_comb begin
    if (int'(size_log2) > DimLog) begin
      eff_log = swm_pkg::SIZE_W'(DimLog);
    end else begin
      eff_log = size_log2;
    end
    nm1 = swm_pkg::IDX_W'((1 << eff_log) - 1);
  end

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last_elem = (i == nm1) && (j == nm1);

  // Commands follow from the state and the loop counters.
  always_comb begin
    cmd.load_wr   = accept;
    cmd.rd_en     = (state == ST_RUN);
    cmd.clear_acc = (state == ST_RUN) && (k == '0);
    cmd.load_out  = (state == ST_DRAIN) && (drain_cnt == 2'd2);
    cmd.last      = last_elem;
    cmd.i         = i;
    cmd.j         = j;
    cmd.k         = k;
  end

  // Sequencer: one dot product per result element, then hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      size_log2 <= swm_pkg::SIZE_RESET;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      drain_cnt <= '0;
    end else begin
      if (cfg_wr_en) begin
        size_log2 <= cfg_wr_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && start_req) begin
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k == nm1) begin
            drain_cnt <= '0;
            state     <= ST_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == 2'd2) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sts.out_done) begin
            k <= '0;
            if (last_elem) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_RUN;
              if (j == nm1) begin
                j <= '0;
                i <= i + 1'b1;
              end else begin
                j <= j + 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/swm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_dp #(
  parameter int DIM = swm_pkg::DIM_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire swm_pkg::cmd_t                      cmd,
  output swm_pkg::sts_t                           sts,
  input  wire logic                               which_matrix,
  input  wire logic        [swm_pkg::IDX_W-1:0]   row,
  input  wire logic        [swm_pkg::IDX_W-1:0]   col,
  input  wire logic signed [swm_pkg::VALUE_W-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic             [swm_pkg::IDX_W-1:0]   out_row,
  output logic             [swm_pkg::IDX_W-1:0]   out_col,
  output logic signed      [swm_pkg::PROD_W-1:0]  product,
  output logic                                    last
);

  localparam int Depth = DIM * DIM;
  localparam int AW    = $clog2(Depth);

  logic                                in_range;
  logic [AW-1:0]                       wr_addr;
  logic [AW-1:0]                       a_addr;
  logic [AW-1:0]                       b_addr;
  logic [swm_pkg::VALUE_W-1:0]         a_rd;
  logic [swm_pkg::VALUE_W-1:0]         b_rd;
  logic                                rd_q;
  logic                                mul_q;
  logic signed [swm_pkg::MUL_W-1:0]    mul;
  logic signed [swm_pkg::PROD_W-1:0]   acc;

  // Store addresses are row-major with stride DIM.
  assign in_range = (int'(row) < DIM) && (int'(col) < DIM);
  assign wr_addr  = AW'(int'(row) * DIM + int'(col));
  assign a_addr   = AW'(int'(cmd.i) * DIM + int'(cmd.k));
  assign b_addr   = AW'(int'(cmd.k) * DIM + int'(cmd.j));

  swm_ram #(.WIDTH(swm_pkg::VALUE_W), .DEPTH(Depth)) u_a_store (
    .clk     (clk),
    .wr_en   (cmd.load_wr && in_range && !which_matrix),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_en   (cmd.rd_en),
    .rd_addr (a_addr),
    .rd_data (a_rd)
  );

  swm_ram #(.WIDTH(swm_pkg::VALUE_W), .DEPTH(Depth)) u_b_store (
    .clk     (clk),
    .wr_en   (cmd.load_wr && in_range && which_matrix),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_en   (cmd.rd_en),
    .rd_addr (b_addr),
    .rd_data (b_rd)
  );

  assign sts.out_done = out_valid && !out_stall;

  // Multiply stage, then accumulate stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_q  <= 1'b0;
      mul_q <= 1'b0;
    end else begin
      rd_q  <= cmd.rd_en;
      mul_q <= rd_q;
    end
    mul <= $signed(a_rd) * $signed(b_rd);
    if (cmd.clear_acc) begin
      acc <= '0;
    end else if (mul_q) begin
      acc <= acc + swm_pkg::PROD_W'(mul);
    end
  end

  // Output register holds one finished element until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (sts.out_done) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      out_row <= cmd.i;
      out_col <= cmd.j;
      product <= acc;
      last    <= cmd.last;
    end
  end

endmodule

`default_nettype wire

### rtl/core/strassen_winograd_matmul.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// config    cfg_wr_en                 cfg_wr_data (size_log2)
// input     in_valid / in_stall       which_matrix, row, col, value, start_req
// output    out_valid / out_stall     out_row, out_col, product, last
//
// Loads are accepted while the block is idle. A start computes each of the n*n
// result elements as a dot product on one multiplier; each element waits in
// the output register until its transfer before the next one is begun.
// Reset is synchronous; the stores hold no reset value. Input is stalled from
// a start until the last element's transfer; output stalls hold the element.

module strassen_winograd_matmul #(
  parameter int DIM = swm_pkg::DIM_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic        [swm_pkg::SIZE_W-1:0]  cfg_wr_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               which_matrix,
  input  wire logic        [swm_pkg::IDX_W-1:0]   row,
  input  wire logic        [swm_pkg::IDX_W-1:0]   col,
  input  wire logic signed [swm_pkg::VALUE_W-1:0] value,
  input  wire logic                               start_req,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic             [swm_pkg::IDX_W-1:0]   out_row,
  output logic             [swm_pkg::IDX_W-1:0]   out_col,
  output logic signed      [swm_pkg::PROD_W-1:0]  product,
  output logic                                    last
);

  swm_pkg::cmd_t cmd;
  swm_pkg::sts_t sts;

  swm_ctrl #(.DIM(DIM)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .start_req   (start_req),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  swm_dp #(.DIM(DIM)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .which_matrix (which_matrix),
    .row          (row),
    .col          (col),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .product      (product),
    .last         (last)
  );

endmodule

`default_nettype wire

### rtl/core/swm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic start_req,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic last
);

  // No new item is taken while a result is on offer.
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // An accepted start request closes the input.
  a_start_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && start_req) |=> in_stall)
    else $error("input not stalled after a start");

  // After the final transfer the output falls quiet.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("result offered after the final element");

  // A stalled result stays on offer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result withdrawn");

endmodule

bind strassen_winograd_matmul swm_checker u_swm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .start_req (start_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .last      (last)
);

`default_nettype wire

### verif/strassen_winograd_matmul_test.sv
`timescale 1ns / 1ps

module strassen_winograd_matmul_test;

  localparam int N_DIM = 8;
  localparam int N_RANDOM = 200;
  localparam int MAX_MISMATCH_REPORTS = 10;

  typedef struct {
    logic [swm_pkg::IDX_W-1:0]         r;
    logic [swm_pkg::IDX_W-1:0]         c;
    logic signed [swm_pkg::PROD_W-1:0] p;
    logic                              lst;
  } elem_t;

  typedef struct {
    logic                               wm;
    logic [swm_pkg::IDX_W-1:0]          r;
    logic [swm_pkg::IDX_W-1:0]          c;
    logic signed [swm_pkg::VALUE_W-1:0] v;
    logic                               go;
  } load_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [swm_pkg::SIZE_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic which_matrix;
  logic [swm_pkg::IDX_W-1:0] row;
  logic [swm_pkg::IDX_W-1:0] col;
  logic signed [swm_pkg::VALUE_W-1:0] value;
  logic start_req;
  logic out_valid;
  logic out_stall;
  logic [swm_pkg::IDX_W-1:0] out_row;
  logic [swm_pkg::IDX_W-1:0] out_col;
  logic signed [swm_pkg::PROD_W-1:0] product;
  logic last;

  strassen_winograd_matmul #(.DIM(N_DIM)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .which_matrix(which_matrix), .row(row), .col(col), .value(value),
    .start_req(start_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row(out_row), .out_col(out_col), .product(product), .last(last)
  );

  // Predictor state: shadow copies of the operand stores and the size register.
  logic signed [swm_pkg::VALUE_W-1:0] mat_a [N_DIM*N_DIM];
  logic signed [swm_pkg::VALUE_W-1:0] mat_b [N_DIM*N_DIM];
  logic [swm_pkg::SIZE_W-1:0] size_sh;
  elem_t pending_elems[$];
  int n_fail;
  int n_mismatch;
  bit idle_en;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Active dimension, clamped to the largest power of two the block supports.
  function automatic int active_n(input logic [swm_pkg::SIZE_W-1:0] sl);
    int n;
    n = 1 << sl;
    while (n > 1 && n > N_DIM) n = n >> 1;
    return n;
  endfunction

  // Product of the active corners, computed by the one-level Winograd scheme.
  task automatic predict_product();
    longint a11[16], a12[16], a21[16], a22[16];
    longint b11[16], b12[16], b21[16], b22[16];
    longint s1[16], s2[16], s3[16], s4[16], s5[16], s6[16], s7[16], s8[16];
    longint m1[16], m2[16], m3[16], m4[16], m5[16], m6[16], m7[16];
    longint cm[64];
    longint v1, v2, v3;
    int n, h, d, r0, r1;
    elem_t e;
    n = active_n(size_sh);
    if (n == 1) begin
      cm[0] = longint'(mat_a[0]) * longint'(mat_b[0]);
    end else begin
      h = n / 2;
      for (int i = 0; i < h; i++)
        for (int j = 0; j < h; j++) begin
          d = i * h + j;
          r0 = i * N_DIM + j;
          r1 = (i + h) * N_DIM + j;
          a11[d] = mat_a[r0]; a12[d] = mat_a[r0 + h];
          a21[d] = mat_a[r1]; a22[d] = mat_a[r1 + h];
          b11[d] = mat_b[r0]; b12[d] = mat_b[r0 + h];
          b21[d] = mat_b[r1]; b22[d] = mat_b[r1 + h];
        end
      for (int q = 0; q < h * h; q++) begin
        s1[q] = a21[q] + a22[q];
        s2[q] = s1[q] - a11[q];
        s3[q] = a11[q] - a21[q];
        s4[q] = a12[q] - s2[q];
        s5[q] = b12[q] - b11[q];
        s6[q] = b22[q] - s5[q];
        s7[q] = b22[q] - b12[q];
        s8[q] = s6[q] - b21[q];
      end
      for (int i = 0; i < h; i++)
        for (int j = 0; j < h; j++) begin
          d = i * h + j;
          m1[d] = 0; m2[d] = 0; m3[d] = 0; m4[d] = 0;
          m5[d] = 0; m6[d] = 0; m7[d] = 0;
          for (int k = 0; k < h; k++) begin
            m1[d] += s2[i*h+k] * s6[k*h+j];
            m2[d] += a11[i*h+k] * b11[k*h+j];
            m3[d] += a12[i*h+k] * b21[k*h+j];
            m4[d] += s3[i*h+k] * s7[k*h+j];
            m5[d] += s1[i*h+k] * s5[k*h+j];
            m6[d] += s4[i*h+k] * b22[k*h+j];
            m7[d] += a22[i*h+k] * s8[k*h+j];
          end
        end
      for (int i = 0; i < h; i++)
        for (int j = 0; j < h; j++) begin
          d = i * h + j;
          v1 = m1[d] + m2[d];
          v2 = v1 + m4[d];
          v3 = m5[d] + m6[d];
          cm[i*n + j] = m2[d] + m3[d];
          cm[i*n + j + h] = v1 + v3;
          cm[(i+h)*n + j] = v2 - m7[d];
          cm[(i+h)*n + j + h] = v2 + m5[d];
        end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        e.r = i[swm_pkg::IDX_W-1:0];
        e.c = j[swm_pkg::IDX_W-1:0];
        e.p = cm[i*n + j][swm_pkg::PROD_W-1:0];
        e.lst = (i == n - 1 && j == n - 1);
        pending_elems.push_back(e);
      end
  endtask

  // Apply an accepted load to the shadow stores and queue the products it asks for.
  task automatic note_load(input load_t t);
    if (t.wm) mat_b[t.r * N_DIM + t.c] = t.v;
    else      mat_a[t.r * N_DIM + t.c] = t.v;
    if (t.go) predict_product();
  endtask

  // Idle cycles drop valid; the payload is held until its transfer.
  task automatic send_load(input load_t t);
    while ($urandom_range(99) < 37 && idle_en) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    which_matrix <= t.wm;
    row <= t.r;
    col <= t.c;
    value <= t.v;
    start_req <= t.go;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    note_load(t);
  endtask

  // Register writes happen only once every expected element has been taken.
  task automatic write_size(input logic [swm_pkg::SIZE_W-1:0] sl);
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= sl;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_sh = sl;
  endtask

  // Fill the whole active corner of both matrices with random content.
  task automatic fill_corner(input int n, input bit extreme);
    load_t t;
    for (int m = 0; m < 2; m++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          t.wm = m[0];
          t.r = i[swm_pkg::IDX_W-1:0];
          t.c = j[swm_pkg::IDX_W-1:0];
          if (extreme) t.v = ($urandom_range(1) != 0) ? 16'sh8000 : 16'sh7fff;
          else t.v = swm_pkg::VALUE_W'($urandom());
          t.go = 1'b0;
          send_load(t);
        end
  endtask

  // Output side: random stalls, each transfer checked against the oldest expectation.
  always @(posedge clk) begin
    elem_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_elems.size() == 0) begin
          n_fail++;
          if (n_mismatch++ < MAX_MISMATCH_REPORTS)
            $display("Unexpected transfer: row %0d col %0d product %0d", out_row, out_col,
                     product);
        end else begin
          e = pending_elems.pop_front();
          if (out_row !== e.r || out_col !== e.c || product !== e.p || last !== e.lst) begin
            n_fail++;
            if (n_mismatch++ < MAX_MISMATCH_REPORTS)
              $display("Mismatch: expected r%0d c%0d %0d last %0b, got r%0d c%0d %0d last %0b",
                       e.r, e.c, e.p, e.lst, out_row, out_col, product, last);
          end
        end
      end
      out_stall <= idle_en && ($urandom_range(99) < 37);
    end
  end

  // Directed rows: load corners, start at each size, and the out-of-range load cases.
  load_t directed [12];

  initial begin
    load_t t;
    int n;
    n_fail = 0;
    n_mismatch = 0;
    idle_en = 1'b1;
    size_sh = swm_pkg::SIZE_RESET;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    which_matrix = 1'b0;
    row = '0;
    col = '0;
    value = '0;
    start_req = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Size 1 with extreme operands: the product can be read off directly.
    write_size(2'd0);
    directed[0] = '{1'b0, 3'd0, 3'd0, 16'sh8000, 1'b0};
    directed[1] = '{1'b1, 3'd0, 3'd0, 16'sh8000, 1'b1};
    directed[2] = '{1'b1, 3'd0, 3'd0, 16'sh7fff, 1'b1};
    directed[3] = '{1'b0, 3'd7, 3'd7, 16'sh7fff, 1'b1};
    for (int q = 0; q < 4; q++) send_load(directed[q]);

    // Full size with extreme contents, then the smaller sizes with random contents.
    write_size(2'd3);
    fill_corner(8, 1'b1);
    directed[4] = '{1'b1, 3'd7, 3'd7, 16'sh8000, 1'b1};
    send_load(directed[4]);
    fill_corner(2, 1'b0);
    write_size(2'd1);
    directed[5] = '{1'b0, 3'd1, 3'd1, 16'sh0001, 1'b1};
    send_load(directed[5]);
    write_size(2'd2);
    fill_corner(4, 1'b0);
    directed[6] = '{1'b1, 3'd3, 3'd0, 16'shffff, 1'b1};
    send_load(directed[6]);

    // Random part: well-formed fills at random sizes, loose loads and starts between.
    for (int q = 0; q < N_RANDOM; q++) begin
      if (q == 70) idle_en = 1'b0;
      if (q == 110) idle_en = 1'b1;
      if (q == 150) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_elems.size() != 0) @(posedge clk);
      end
      if (q % 60 == 0) begin
        write_size(swm_pkg::SIZE_W'($urandom_range(3)));
        n = active_n(size_sh);
        if (n < 8) fill_corner(n, $urandom_range(3) == 0);
      end
      t.wm = 1'($urandom_range(1));
      t.r = swm_pkg::IDX_W'($urandom_range(n - 1 + (($urandom_range(4) == 0) ? 8 - n : 0)));
      t.c = swm_pkg::IDX_W'($urandom_range(n - 1 + (($urandom_range(4) == 0) ? 8 - n : 0)));
      t.v = swm_pkg::VALUE_W'($urandom());
      t.go = ($urandom_range(99) < ((n == 8) ? 4 : 20));
      send_load(t);
    end

    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_fail == 0) $display("strassen_winograd_matmul test passed");
    else $display("strassen_winograd_matmul test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("strassen_winograd_matmul test failed");
    $finish;
  end

endmodule
